// ===== rtl/head_tail_free_list_block_pool_assert.svh =====
// assertion macros shared by the block pool sources
`ifndef HEAD_TAIL_FREE_LIST_BLOCK_POOL_ASSERT_SVH
`define HEAD_TAIL_FREE_LIST_BLOCK_POOL_ASSERT_SVH
`ifndef SYNTH
`define HTFL_ASSERT_CLK(label, clk_s, rst_n_s, prop, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) else $error(msg);
`define HTFL_ASSERT(label, prop, msg) \
	`HTFL_ASSERT_CLK(label, clk, arst_n, prop, msg)
`else
`define HTFL_ASSERT_CLK(label, clk_s, rst_n_s, prop, msg)
`define HTFL_ASSERT(label, prop, msg)
`endif
`endif

// ===== rtl/htfl_pkg.sv =====
package htfl_pkg;

	localparam int DEF_MAX_BLOCKS = 1024;
	localparam int ADDR_W         = 32;
	localparam int BYTES_W        = 21;
	localparam int BB_W           = 17;
	localparam int LEN_W          = 18;
	localparam int QUO_W          = 21;
	localparam int CNT_W          = 11;
	localparam int COUNT_MAX      = 2047;
	localparam int CFG_IDX_W      = 2;
	localparam int IN_TDATA_W     = 40;
	localparam int OUT_TDATA_W    = 48;

	localparam logic [BB_W-1:0] BLOCK_BYTES_RST = BB_W'(32);

	localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_BYTES  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 2'd2;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef struct packed {
		logic             start;
		logic [QUO_W-1:0] dividend;
		logic [LEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quotient;
		logic [LEN_W-1:0] remainder;
	} div_rsp_t;

	// block length: zero taken as one, rounded up to a multiple of 4
	function automatic logic [LEN_W-1:0] blk_len(input logic [BB_W-1:0] bb);
		logic [LEN_W-1:0] b;
		b = (bb == '0) ? LEN_W'(1) : LEN_W'(bb);
		b = b + LEN_W'(3);
		return {b[LEN_W-1:2], 2'b00};
	endfunction

endpackage

// ===== rtl/htfl_div.sv =====
`include "head_tail_free_list_block_pool_assert.svh"

module htfl_div import htfl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int ITER_W = $clog2(QUO_W);

	logic              busy_q;
	logic              done_q;
	logic [ITER_W-1:0] cnt_q;
	logic [QUO_W-1:0]  quo_q;
	logic [LEN_W-1:0]  rem_q;
	logic [LEN_W-1:0]  dsr_q;

	logic [LEN_W:0] shifted;
	logic [LEN_W:0] trial;
	logic           ge;

	always_comb begin
		shifted = {rem_q, quo_q[QUO_W-1]};
		ge      = shifted >= {1'b0, dsr_q};
		trial   = shifted - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dsr_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= req.dividend;
			rem_q  <= '0;
			dsr_q  <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? trial[LEN_W-1:0] : shifted[LEN_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
			cnt_q <= cnt_q + ITER_W'(1);
			if (cnt_q == ITER_W'(QUO_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

	`HTFL_ASSERT(a_div_start_busy, req.start |=> busy_q, "divider did not go busy on start")
	`HTFL_ASSERT(a_div_done_after_busy, done_q |-> $past(busy_q), "divider done without a pass")
	`HTFL_ASSERT(a_div_rem_bound, (busy_q && dsr_q != '0) |-> (rem_q < dsr_q), "partial remainder out of bound")

endmodule

// ===== rtl/htfl_link_ram.sv =====
module htfl_link_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/head_tail_free_list_block_pool.sv =====
// allocate: link read and multiply, add, then load of the result; straight to load if the list is empty
// free: range check, the 21-step divider that checks alignment, a second link write when
//   appended behind a tail, then load; the divider is skipped when out of range
// one request at a time, the next taken in the cycle after a result is loaded
// reset or a config write: divider pass, then one link write per block,
//   with no requests taken until the list is rebuilt
`include "head_tail_free_list_block_pool_assert.svh"

module head_tail_free_list_block_pool import htfl_pkg::*; #(
	parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [ADDR_W-1:0]      cfg_wdata,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // block_addr[31:0], to_head[32], zero
	input  logic [0:0]             s_axis_tuser,  // req_type[0]
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata   // ok[0], granted_addr[32:1], free_blocks[43:33], zero
);

	localparam int AW = $clog2(MAX_BLOCKS);
	localparam int IW = $clog2(MAX_BLOCKS + 1);
	localparam int CW = (IW > CNT_W) ? IW : CNT_W;
	localparam int PW = (AW + LEN_W > ADDR_W) ? AW + LEN_W : ADDR_W;
	localparam logic [IW-1:0]    LIST_END = IW'(MAX_BLOCKS);
	localparam logic [QUO_W-1:0] MAX_Q    = QUO_W'(MAX_BLOCKS);

	typedef enum logic [3:0] {
		ST_CFG_START,
		ST_CFG_DIV,
		ST_SWEEP,
		ST_IDLE,
		ST_ALLOC_RD,
		ST_ALLOC_ADD,
		ST_FREE_CHK,
		ST_FREE_DIV,
		ST_FREE_W2,
		ST_RESULT
	} state_t;

	state_t state_q;

	logic [ADDR_W-1:0]  pool_base_q;
	logic [BYTES_W-1:0] pool_bytes_q;
	logic [BB_W-1:0]    block_bytes_q;

	logic [IW-1:0]     head_q;
	logic [IW-1:0]     tail_q;
	logic [IW-1:0]     count_q;
	logic [CW-1:0]     free_q;
	logic [AW-1:0]     sweep_q;
	logic [AW-1:0]     idx_q;
	logic [ADDR_W-1:0] addr_q;
	logic              to_head_q;
	logic [ADDR_W-1:0] prod_s1;
	logic              res_ok_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic              m_valid_q;
	logic              m_ok_q;
	logic [ADDR_W-1:0] m_addr_q;
	logic [CNT_W-1:0]  m_free_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [IW-1:0] ram_wdata;
	logic          ram_re;
	logic [IW-1:0] ram_rdata;

	logic [LEN_W-1:0]  len;
	logic              cfg_hit;
	logic              in_accept;
	logic              out_free;
	logic [ADDR_W:0]   diff;
	logic              in_range;
	logic              blk_ok;
	logic [AW-1:0]     q_idx;
	logic [IW-1:0]     cnt_new;
	logic [IW-1:0]     rd_next;
	logic [IW-1:0]     sweep_next;
	logic [PW-1:0]     prod_full;
	logic [CW-1:0]     free_dec;
	logic [CW-1:0]     free_inc;

	always_comb begin
		len        = blk_len(block_bytes_q);
		cfg_hit    = cfg_we && (cfg_index == CFG_POOL_BASE || cfg_index == CFG_POOL_BYTES ||
			cfg_index == CFG_BLOCK_BYTES);
		in_accept  = s_axis_tvalid && s_axis_tready;
		out_free   = !m_valid_q || m_axis_tready;
		diff       = {1'b0, addr_q} - {1'b0, pool_base_q};
		in_range   = !diff[ADDR_W] && (diff[ADDR_W-1:0] < ADDR_W'(pool_bytes_q));
		blk_ok     = (div_rsp.remainder == '0) && (div_rsp.quotient < QUO_W'(count_q));
		q_idx      = div_rsp.quotient[AW-1:0];
		cnt_new    = (div_rsp.quotient > MAX_Q) ? LIST_END : div_rsp.quotient[IW-1:0];
		rd_next    = (ram_rdata >= LIST_END) ? LIST_END : ram_rdata;
		sweep_next = IW'(sweep_q) + IW'(1);
		prod_full  = PW'(idx_q) * PW'(len);
		free_dec   = (free_q == '0) ? free_q : free_q - CW'(1);
		free_inc   = (free_q < CW'(COUNT_MAX)) ? free_q + CW'(1) : free_q;
	end

	// divider requests: block count on rebuild, offset / length on free
	always_comb begin
		div_req.start    = (state_q == ST_CFG_START) || (state_q == ST_FREE_CHK && in_range);
		div_req.dividend = (state_q == ST_CFG_START) ? pool_bytes_q : diff[QUO_W-1:0];
		div_req.divisor  = len;
	end

	// link memory port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = sweep_q;
		ram_wdata = LIST_END;
		ram_re    = in_accept && (s_axis_tuser[0] == REQ_ALLOC) && (head_q != LIST_END);
		unique case (state_q)
			ST_SWEEP: begin
				ram_we    = 1'b1;
				ram_waddr = sweep_q;
				ram_wdata = (sweep_next < count_q) ? sweep_next : LIST_END;
			end
			ST_FREE_DIV: begin
				if (div_rsp.done && blk_ok) begin
					ram_we = 1'b1;
					if (to_head_q) begin
						ram_waddr = q_idx;
						ram_wdata = head_q;
					end else if (tail_q == LIST_END) begin
						ram_waddr = q_idx;
						ram_wdata = LIST_END;
					end else begin
						ram_waddr = tail_q[AW-1:0];
						ram_wdata = IW'(q_idx);
					end
				end
			end
			ST_FREE_W2: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = LIST_END;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q   <= '0;
			pool_bytes_q  <= '0;
			block_bytes_q <= BLOCK_BYTES_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_POOL_BASE:   pool_base_q   <= cfg_wdata;
				CFG_POOL_BYTES:  pool_bytes_q  <= cfg_wdata[BYTES_W-1:0];
				CFG_BLOCK_BYTES: block_bytes_q <= cfg_wdata[BB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CFG_START;
			head_q     <= LIST_END;
			tail_q     <= LIST_END;
			count_q    <= '0;
			free_q     <= '0;
			sweep_q    <= '0;
			idx_q      <= '0;
			addr_q     <= '0;
			to_head_q  <= 1'b0;
			prod_s1    <= '0;
			res_ok_q   <= 1'b0;
			res_addr_q <= '0;
			m_valid_q  <= 1'b0;
			m_ok_q     <= 1'b0;
			m_addr_q   <= '0;
			m_free_q   <= '0;
		end else begin
			if (state_q == ST_RESULT && out_free) begin
				m_valid_q <= 1'b1;
				m_ok_q    <= res_ok_q;
				m_addr_q  <= res_addr_q;
				m_free_q  <= free_q[CNT_W-1:0];
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end

			if (cfg_hit) begin
				state_q <= ST_CFG_START;
			end else begin
				unique case (state_q)
					ST_CFG_START: state_q <= ST_CFG_DIV;
					ST_CFG_DIV: begin
						if (div_rsp.done) begin
							count_q <= cnt_new;
							free_q  <= CW'(cnt_new);
							sweep_q <= '0;
							if (cnt_new == '0) begin
								head_q  <= LIST_END;
								tail_q  <= LIST_END;
								state_q <= ST_IDLE;
							end else begin
								head_q  <= '0;
								tail_q  <= cnt_new - IW'(1);
								state_q <= ST_SWEEP;
							end
						end
					end
					ST_SWEEP: begin
						sweep_q <= sweep_q + AW'(1);
						if (IW'(sweep_q) == count_q - IW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (in_accept) begin
							addr_q    <= s_axis_tdata[ADDR_W-1:0];
							to_head_q <= s_axis_tdata[ADDR_W];
							if (s_axis_tuser[0] == REQ_FREE) begin
								state_q <= ST_FREE_CHK;
							end else if (head_q == LIST_END) begin
								res_ok_q   <= 1'b0;
								res_addr_q <= '0;
								state_q    <= ST_RESULT;
							end else begin
								idx_q   <= head_q[AW-1:0];
								state_q <= ST_ALLOC_RD;
							end
						end
					end
					ST_ALLOC_RD: begin
						head_q  <= rd_next;
						if (rd_next == LIST_END) begin
							tail_q <= LIST_END;
						end
						free_q  <= free_dec;
						prod_s1 <= prod_full[ADDR_W-1:0];
						state_q <= ST_ALLOC_ADD;
					end
					ST_ALLOC_ADD: begin
						res_ok_q   <= 1'b1;
						res_addr_q <= pool_base_q + prod_s1;
						state_q    <= ST_RESULT;
					end
					ST_FREE_CHK: begin
						if (in_range) begin
							state_q <= ST_FREE_DIV;
						end else begin
							res_ok_q   <= 1'b0;
							res_addr_q <= '0;
							state_q    <= ST_RESULT;
						end
					end
					ST_FREE_DIV: begin
						if (div_rsp.done) begin
							res_addr_q <= '0;
							if (blk_ok) begin
								idx_q    <= q_idx;
								free_q   <= free_inc;
								res_ok_q <= 1'b1;
								if (to_head_q) begin
									head_q <= IW'(q_idx);
									if (tail_q == LIST_END) begin
										tail_q <= IW'(q_idx);
									end
									state_q <= ST_RESULT;
								end else begin
									tail_q <= IW'(q_idx);
									if (tail_q == LIST_END) begin
										head_q  <= IW'(q_idx);
										state_q <= ST_RESULT;
									end else begin
										state_q <= ST_FREE_W2;
									end
								end
							end else begin
								res_ok_q <= 1'b0;
								state_q  <= ST_RESULT;
							end
						end
					end
					ST_FREE_W2: state_q <= ST_RESULT;
					ST_RESULT: begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end
					end
					default: state_q <= ST_CFG_START;
				endcase
			end
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - CNT_W - ADDR_W - 1){1'b0}}, m_free_q, m_addr_q, m_ok_q};

	htfl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	htfl_link_ram #(
		.DEPTH (MAX_BLOCKS),
		.AW    (AW),
		.DW    (IW)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (head_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	`HTFL_ASSERT(a_list_ends_agree, (state_q == ST_IDLE) |-> ((head_q == LIST_END) == (tail_q == LIST_END)), "head and tail disagree on empty list")
	`HTFL_ASSERT(a_head_in_pool, (state_q == ST_IDLE && head_q != LIST_END) |-> (head_q < count_q), "head index beyond block count")
	`HTFL_ASSERT(a_no_link_write_idle, (state_q == ST_IDLE || state_q == ST_RESULT) |-> !ram_we, "link write outside an update")

endmodule

// ===== verif/head_tail_free_list_block_pool_tb.sv =====
`timescale 1ns / 1ps

module head_tail_free_list_block_pool_tb;
	import htfl_pkg::*;

	localparam int LIST_END = DEF_MAX_BLOCKS;

	typedef struct packed {
		bit        ok;
		bit [31:0] granted;
		bit [10:0] free_blocks;
	} pool_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [ADDR_W-1:0]      cfg_wdata;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic [0:0]             s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// pool model state
	bit [31:0] cfg_base;
	bit [20:0] cfg_bytes;
	bit [16:0] cfg_bb;
	bit [10:0] link_mem [0:DEF_MAX_BLOCKS-1];
	bit [10:0] head_idx;
	bit [10:0] tail_idx;
	bit [10:0] free_cnt;

	pool_result_t expected_q [$];
	bit [31:0]    held_q [$];
	int unsigned  mismatch_count;
	int unsigned  stall_left;
	bit           quiet_mode;

	head_tail_free_list_block_pool dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic int unsigned unit_len();
		int unsigned b;
		b = (cfg_bb == 0) ? 1 : cfg_bb;
		return (b + 3) / 4 * 4;
	endfunction

	function automatic int unsigned block_total();
		int unsigned n;
		n = cfg_bytes / unit_len();
		return (n > DEF_MAX_BLOCKS) ? DEF_MAX_BLOCKS : n;
	endfunction

	function automatic void rebuild_list();
		int unsigned n;
		n = block_total();
		for (int i = 0; i < DEF_MAX_BLOCKS; i++)
			link_mem[i] = (i + 1 < n) ? 11'(i + 1) : 11'(LIST_END);
		head_idx = (n != 0) ? 11'd0 : 11'(LIST_END);
		tail_idx = (n != 0) ? 11'(n - 1) : 11'(LIST_END);
		free_cnt = 11'(n);
	endfunction

	function automatic pool_result_t predict_request(bit req, bit [31:0] addr, bit to_head);
		pool_result_t res;
		int unsigned  len;
		bit [10:0]    idx;
		bit [10:0]    nxt;
		bit [31:0]    off;
		bit [32:0]    pool_end;
		res = '0;
		len = unit_len();
		if (req == REQ_ALLOC) begin
			if (head_idx < LIST_END) begin
				idx = head_idx;
				nxt = link_mem[idx];
				if (nxt >= LIST_END)
					nxt = 11'(LIST_END);
				res.granted = cfg_base + 32'(idx) * len;
				head_idx = nxt;
				if (nxt == LIST_END)
					tail_idx = 11'(LIST_END);
				if (free_cnt > 0)
					free_cnt--;
				res.ok = 1'b1;
			end
		end else begin
			pool_end = {1'b0, cfg_base} + 33'(cfg_bytes);
			off = addr - cfg_base;
			if (addr >= cfg_base && {1'b0, addr} < pool_end &&
					off % len == 0 && off / len < block_total()) begin
				idx = 11'(off / len);
				if (to_head) begin
					link_mem[idx] = head_idx;
					head_idx = idx;
					if (tail_idx >= LIST_END)
						tail_idx = idx;
				end else begin
					if (tail_idx >= LIST_END)
						head_idx = idx;
					else
						link_mem[tail_idx] = idx;
					tail_idx = idx;
					link_mem[idx] = 11'(LIST_END);
				end
				if (free_cnt < COUNT_MAX)
					free_cnt++;
				res.ok = 1'b1;
			end
		end
		res.free_blocks = free_cnt;
		return res;
	endfunction

	function automatic int unsigned idle_len();
		int unsigned r;
		if (quiet_mode)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_request(input bit req, input bit [31:0] addr, input bit to_head);
		int unsigned  gap;
		pool_result_t res;
		gap = idle_len();
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'b0, to_head, addr};
		s_axis_tuser  <= req;
		do
			@(posedge clk);
		while (!s_axis_tready);
		res = predict_request(req, addr, to_head);
		expected_q.push_back(res);
		if (req == REQ_ALLOC && res.ok)
			held_q.push_back(res.granted);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_pool(input bit [31:0] base, input bit [31:0] bytes, input bit [31:0] bb);
		bit [CFG_IDX_W-1:0] codes [3];
		bit [31:0]          vals [3];
		bit [CFG_IDX_W-1:0] tmp_code;
		bit [31:0]          tmp_val;
		int unsigned        j;
		codes = '{CFG_POOL_BASE, CFG_POOL_BYTES, CFG_BLOCK_BYTES};
		vals = '{base, bytes, bb};
		for (int k = 2; k > 0; k--) begin
			j = $urandom_range(0, k);
			tmp_code = codes[k]; codes[k] = codes[j]; codes[j] = tmp_code;
			tmp_val = vals[k]; vals[k] = vals[j]; vals[j] = tmp_val;
		end
		drain_results();
		for (int k = 0; k < 3; k++) begin
			cfg_we    <= 1'b1;
			cfg_index <= codes[k];
			cfg_wdata <= vals[k];
			case (codes[k])
				CFG_POOL_BASE:   cfg_base = vals[k];
				CFG_POOL_BYTES:  cfg_bytes = vals[k][20:0];
				CFG_BLOCK_BYTES: cfg_bb = vals[k][16:0];
				default: ;
			endcase
			rebuild_list();
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		held_q.delete();
	endtask

	task automatic test_empty_after_reset();
		send_request(REQ_ALLOC, 32'hFFFF_FFFF, 1'b1);
		send_request(REQ_FREE, 32'h0, 1'b0);
	endtask

	// three whole blocks of 32 bytes plus a 4 byte remnant
	task automatic test_basic_pool();
		set_pool(32'h1000, 100, 30);
		repeat (4) send_request(REQ_ALLOC, $urandom, 1'b0);
		send_request(REQ_FREE, 32'h1060, 1'b0);
		send_request(REQ_FREE, 32'h1064, 1'b1);
		send_request(REQ_FREE, 32'h0FE0, 1'b0);
		send_request(REQ_FREE, 32'h1021, 1'b1);
		send_request(REQ_FREE, 32'h1020, 1'b1);
		send_request(REQ_FREE, 32'h1000, 1'b0);
		repeat (2) send_request(REQ_ALLOC, 32'h0, 1'b0);
	endtask

	task automatic test_address_wrap();
		set_pool(32'hFFFF_FF00, 32'h200, 64);
		repeat (5) send_request(REQ_ALLOC, $urandom, 1'b1);
		send_request(REQ_FREE, 32'h0, 1'b1);
		send_request(REQ_FREE, 32'hFFFF_FF40, 1'b1);
	endtask

	// zero block length and a block count past the limit
	task automatic test_block_count_limit();
		set_pool(32'h100, 32'h1F_FFFF, 0);
		send_request(REQ_FREE, 32'h100 + 32'd4096, 1'b1);
		send_request(REQ_FREE, 32'h100, 1'b1);
		send_request(REQ_FREE, 32'h100 + 32'd4092, 1'b0);
		send_request(REQ_ALLOC, 32'h0, 1'b0);
	endtask

	task automatic test_random_traffic();
		int unsigned r;
		int unsigned len;
		int unsigned cnt;
		int unsigned pick;
		bit [31:0]   addr;
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: set_pool($urandom, $urandom_range(0, 512), $urandom_range(1, 64));
				1: set_pool(32'h0, 32'h10_0000, 1);
				2: set_pool(32'hFFFF_FFFF, 32'h1F_FFFF, 32'h1_FFFF);
				3: set_pool($urandom, $urandom_range(0, 2048) | ($urandom & 32'hFFE0_0000),
						$urandom_range(0, 40) | ($urandom & 32'hFFFE_0000));
				4: set_pool($urandom & 32'hFFFF_0000, 32'h10_0000, 65536);
				default: set_pool($urandom, $urandom_range(64, 1024), $urandom_range(1, 16));
			endcase
			for (int n = 0; n < 150; n++) begin
				if (n % 50 == 0)
					quiet_mode = ($urandom_range(0, 4) == 0);
				if (n == 75)
					drain_results();
				len = unit_len();
				cnt = block_total();
				r = $urandom_range(0, 99);
				if (r < 45 || (r < 80 && held_q.size() == 0)) begin
					send_request(REQ_ALLOC, $urandom, $urandom_range(0, 1));
				end else begin
					if (r < 80) begin
						pick = $urandom_range(0, held_q.size() - 1);
						addr = held_q[pick];
						held_q.delete(pick);
					end else if (r < 88) begin
						addr = cfg_base + $urandom_range(0, (cnt != 0) ? cnt - 1 : 0) * len;
					end else if (r < 94) begin
						addr = cfg_base + $urandom_range(0, cnt) * len + $urandom_range(1, len - 1);
					end else begin
						addr = $urandom;
					end
					send_request(REQ_FREE, addr, $urandom_range(0, 1));
				end
			end
		end
		quiet_mode = 1'b0;
	endtask

	initial begin
		pool_result_t exp_res;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_q.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected result: expected none, actual %h", $time,
						m_axis_tdata);
				end else begin
					exp_res = expected_q.pop_front();
					if (m_axis_tdata[0] !== exp_res.ok) begin
						mismatch_count++;
						$display("%0t: ok mismatch: expected %0d, actual %0d", $time,
							exp_res.ok, m_axis_tdata[0]);
					end
					if (m_axis_tdata[32:1] !== exp_res.granted) begin
						mismatch_count++;
						$display("%0t: granted_addr mismatch: expected %h, actual %h", $time,
							exp_res.granted, m_axis_tdata[32:1]);
					end
					if (m_axis_tdata[43:33] !== exp_res.free_blocks) begin
						mismatch_count++;
						$display("%0t: free_blocks mismatch: expected %0d, actual %0d", $time,
							exp_res.free_blocks, m_axis_tdata[43:33]);
					end
				end
			end
			if (stall_left != 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = idle_len();
			end
		end
	end

	initial begin
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= CFG_POOL_BASE;
		cfg_wdata     <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= REQ_ALLOC;
		m_axis_tready <= 1'b0;
		mismatch_count = 0;
		quiet_mode = 1'b0;
		cfg_base = '0;
		cfg_bytes = '0;
		cfg_bb = BLOCK_BYTES_RST;
		rebuild_list();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_after_reset();
		test_basic_pool();
		test_address_wrap();
		test_block_count_limit();
		test_random_traffic();

		drain_results();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/htfl_pkg.sv
rtl/htfl_div.sv
rtl/htfl_link_ram.sv
rtl/head_tail_free_list_block_pool.sv
verif/head_tail_free_list_block_pool_tb.sv
